FILE: rtl/stx_etx_frame_deframer_defines.svh
// assertion macros for the stx/etx frame deframer
// expects clk and arst_n in the scope of each use
`ifndef STX_ETX_FRAME_DEFRAMER_DEFINES_SVH
`define STX_ETX_FRAME_DEFRAMER_DEFINES_SVH

// same-cycle implication
`define SEFD_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sefd assertion failed");

// next-cycle implication
`define SEFD_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sefd assertion failed");

`endif

FILE: rtl/sefd_pkg.sv
// types and constants for the stx/etx frame deframer
// no dependencies
package sefd_pkg;

	localparam logic [7:0] STX_BYTE = 8'h02;
	localparam logic [7:0] ETX_BYTE = 8'h03;
	localparam logic [7:0] CR_BYTE  = 8'h0D;

	typedef enum logic [1:0] {
		KIND_DATA   = 2'd0,
		KIND_ACCEPT = 2'd1,
		KIND_REJECT = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		CAUSE_NONE     = 2'd0,
		CAUSE_FRAMING  = 2'd1,
		CAUSE_CHECKSUM = 2'd2
	} cause_t;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'b001,
		PH_HEADER  = 3'b010,
		PH_PAYLOAD = 3'b100
	} phase_t;

endpackage

FILE: rtl/stx_etx_frame_deframer.sv
// STX/ETX frame deframer with additive checksum, top level
// depends on sefd_pkg and stx_etx_frame_deframer_defines.svh
//
// Takes one received byte per transfer and sustains one byte per clock cycle while the
// result side does not stall: the byte is registered on input, then one pass of
// frame-state logic updates the parser and loads the result register. Bytes outside a
// frame are dropped; payload bytes come out as they arrive; at the CR slot one end item
// reports the frame accepted or rejected with its cause. A stall on the result side holds
// the result register and, through it, the input register, so rx_stall follows res_stall
// once both registers are full.
`include "stx_etx_frame_deframer_defines.svh"

module stx_etx_frame_deframer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rx_valid,
	output logic                 rx_stall,
	input  logic [7:0]           rx_byte,
	output logic                 res_valid,
	input  logic                 res_stall,
	output sefd_pkg::kind_t      kind,
	output logic [7:0]           data_byte,
	output logic [7:0]           data_index,
	output logic [7:0]           frame_addr,
	output logic [7:0]           frame_cmd,
	output logic [7:0]           frame_len,
	output sefd_pkg::cause_t     error_cause
);
	import sefd_pkg::*;

	// input register
	logic       v_s1;
	logic [7:0] byte_s1;

	// frame state
	phase_t     phase_q;
	logic [8:0] bytes_left_q;
	logic [7:0] data_count_q;
	logic [7:0] hdr_addr_q;
	logic [7:0] hdr_cmd_q;
	logic [7:0] payload_len_q;
	logic [7:0] running_sum_q;
	logic       end_ok_q;
	logic [7:0] sum_rcv_q;

	phase_t     phase_d;
	logic [8:0] bytes_left_d;
	logic [7:0] data_count_d;
	logic [7:0] hdr_addr_d;
	logic [7:0] hdr_cmd_d;
	logic [7:0] payload_len_d;
	logic [7:0] running_sum_d;
	logic       end_ok_d;
	logic [7:0] sum_rcv_d;

	logic       res_d;
	kind_t      kind_d;
	logic [7:0] dbyte_d;
	logic [7:0] didx_d;
	cause_t     cause_d;

	logic       adv;
	logic       fire;
	logic [7:0] sum_add;

	assign adv      = !res_valid || !res_stall;
	assign fire     = v_s1 && adv;
	assign rx_stall = v_s1 && !adv;
	assign sum_add  = running_sum_q + byte_s1;

	always_comb begin
		phase_d       = phase_q;
		bytes_left_d  = bytes_left_q;
		data_count_d  = data_count_q;
		hdr_addr_d    = hdr_addr_q;
		hdr_cmd_d     = hdr_cmd_q;
		payload_len_d = payload_len_q;
		running_sum_d = running_sum_q;
		end_ok_d      = end_ok_q;
		sum_rcv_d     = sum_rcv_q;
		res_d         = 1'b0;
		kind_d        = KIND_DATA;
		dbyte_d       = 8'd0;
		didx_d        = 8'd0;
		cause_d       = CAUSE_NONE;
		unique case (phase_q)
			PH_HEADER: begin
				running_sum_d = sum_add;
				priority if (bytes_left_q == 9'd3) begin
					hdr_addr_d   = byte_s1;
					bytes_left_d = 9'd2;
				end else if (bytes_left_q == 9'd2) begin
					hdr_cmd_d    = byte_s1;
					bytes_left_d = 9'd1;
				end else begin
					payload_len_d = byte_s1;
					data_count_d  = 8'd0;
					bytes_left_d  = {1'b0, byte_s1} + 9'd3;
					phase_d       = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				priority if (bytes_left_q > 9'd3) begin
					running_sum_d = sum_add;
					data_count_d  = data_count_q + 8'd1;
					bytes_left_d  = bytes_left_q - 9'd1;
					res_d         = 1'b1;
					dbyte_d       = byte_s1;
					didx_d        = data_count_q;
				end else if (bytes_left_q == 9'd3) begin
					running_sum_d = sum_add;
					end_ok_d      = (byte_s1 == ETX_BYTE);
					bytes_left_d  = 9'd2;
				end else if (bytes_left_q == 9'd2) begin
					sum_rcv_d    = byte_s1;
					bytes_left_d = 9'd1;
				end else begin
					res_d = 1'b1;
					priority if (byte_s1 != CR_BYTE || !end_ok_q) begin
						cause_d = CAUSE_FRAMING;
					end else if (sum_rcv_q != running_sum_q) begin
						cause_d = CAUSE_CHECKSUM;
					end else begin
						cause_d = CAUSE_NONE;
					end
					kind_d       = (cause_d == CAUSE_NONE) ? KIND_ACCEPT : KIND_REJECT;
					phase_d      = PH_HUNT;
					bytes_left_d = 9'd0;
				end
			end
			default: begin
				if (byte_s1 == STX_BYTE) begin
					phase_d       = PH_HEADER;
					bytes_left_d  = 9'd3;
					running_sum_d = STX_BYTE;
					data_count_d  = 8'd0;
					end_ok_d      = 1'b0;
					sum_rcv_d     = 8'd0;
				end else begin
					phase_d = PH_HUNT;
				end
			end
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!rx_stall) begin
			v_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HUNT;
			bytes_left_q  <= 9'd0;
			data_count_q  <= 8'd0;
			hdr_addr_q    <= 8'd0;
			hdr_cmd_q     <= 8'd0;
			payload_len_q <= 8'd0;
			running_sum_q <= 8'd0;
			end_ok_q      <= 1'b0;
			sum_rcv_q     <= 8'd0;
		end else if (fire) begin
			phase_q       <= phase_d;
			bytes_left_q  <= bytes_left_d;
			data_count_q  <= data_count_d;
			hdr_addr_q    <= hdr_addr_d;
			hdr_cmd_q     <= hdr_cmd_d;
			payload_len_q <= payload_len_d;
			running_sum_q <= running_sum_d;
			end_ok_q      <= end_ok_d;
			sum_rcv_q     <= sum_rcv_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (adv) begin
			res_valid <= fire && res_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_d) begin
			kind        <= kind_d;
			data_byte   <= dbyte_d;
			data_index  <= didx_d;
			frame_addr  <= hdr_addr_q;
			frame_cmd   <= hdr_cmd_q;
			frame_len   <= payload_len_q;
			error_cause <= cause_d;
		end
	end

	`SEFD_ASSERT_NEXT(a_rx_lands, rx_valid && !rx_stall, v_s1)
	`SEFD_ASSERT_NOW(a_hunt_idle, phase_q == PH_HUNT, bytes_left_q == 9'd0)
	`SEFD_ASSERT_NOW(a_data_in_range, res_valid && kind == KIND_DATA,
		error_cause == CAUSE_NONE && data_index < frame_len)
	`SEFD_ASSERT_NOW(a_count_bound, phase_q == PH_PAYLOAD, data_count_q <= payload_len_q)

endmodule
